/* rtl/sai_pkg.sv */
// ----------------------------------------------------------------------------
// sai_pkg: shared types and constants of the sorted insert core
// Payload types, status codes and the job format passed front to back.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int VALUE_W      = 32;
    localparam int MOVES_W      = 11;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [MOVES_W-1:0]        t_moves;
    typedef logic                      t_status;

    localparam t_status ST_INSERTED = 1'b0;
    localparam t_status ST_FULL     = 1'b1;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic   full;
        t_value value;
    } t_job;

endpackage

/* rtl/sai_if.sv */
// ----------------------------------------------------------------------------
// sai_if: channel interfaces of the sorted insert core
// Valid/ready channels for insert values and insert results.
// ----------------------------------------------------------------------------
interface sai_value_if;
    import sai_pkg::*;
    logic   valid;
    logic   ready;
    t_value value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sai_result_if;
    import sai_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_moves  moves;
    modport source (output valid, output status, output moves, input ready);
    modport sink   (input valid, input status, input moves, output ready);
endinterface

/* rtl/sai_ram.sv */
// ----------------------------------------------------------------------------
// sai_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/sai_queue.sv */
// ----------------------------------------------------------------------------
// sai_queue: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sai_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sai_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sai_pkg::t_job   o_job
);
    import sai_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];
endmodule

/* rtl/sai_front.sv */
// ----------------------------------------------------------------------------
// sai_front: input stage of the sorted insert core
// Accepts values and marks each one as insert or table full.
// ----------------------------------------------------------------------------
module sai_front #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sai_value_if.sink                     i_value,
    input  logic                          i_q_full,
    output logic                          o_push,
    output sai_pkg::t_job                 o_job,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);
    import sai_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Count of inserts already committed to the queue or the back end.
    logic [CNT_W-1:0] r_count, n_count;
    logic             full;

    assign full           = (r_count == CNT_W'(CAPACITY));
    assign i_value.ready  = !i_q_full;
    assign o_push         = i_value.valid && !i_q_full;
    assign o_job.full     = full;
    assign o_job.value    = i_value.value;

    always_comb begin
        n_count = r_count;
        if (o_push && !full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
endmodule

/* rtl/sai_back.sv */
// ----------------------------------------------------------------------------
// sai_back: insert engine of the sorted insert core
// Walks the table downward, shifting larger entries up, then writes the value.
// ----------------------------------------------------------------------------
module sai_back #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  sai_pkg::t_job                 i_job,
    output logic                          o_job_pop,
    sai_result_if.source                  o_result,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);
    import sai_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CMP    = 2'd1;
    localparam logic [1:0] S_LAST   = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_shift, n_shift;
    logic [ADDR_W-1:0] r_pos, n_pos;
    t_value            r_val, n_val;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    t_moves            r_out_moves, n_out_moves;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;
    logic              gt;
    logic              out_free;

    sai_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign gt       = (t_value'(ram_rdata) > r_val);
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_shift      = r_shift;
        n_pos        = r_pos;
        n_val        = r_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_moves  = r_out_moves;
        o_job_pop    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_val;
        ram_raddr    = r_pos - ADDR_W'(2);

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_shift   = '0;
                    n_val     = i_job.value;
                    if (i_job.full) begin
                        n_status = ST_FULL;
                        n_state  = S_REPORT;
                    end else if (r_count == '0) begin
                        // empty table: write slot zero directly
                        n_status  = ST_INSERTED;
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = i_job.value;
                        n_count   = r_count + CNT_W'(1);
                        n_state   = S_REPORT;
                    end else begin
                        n_status  = ST_INSERTED;
                        n_pos     = ADDR_W'(r_count);
                        ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                        n_state   = S_CMP;
                    end
                end
            end
            S_CMP: begin
                ram_we = 1'b1;
                if (gt) begin
                    // move the larger entry up and fetch the next one down
                    ram_wdata = ram_rdata;
                    n_shift   = r_shift + CNT_W'(1);
                    n_pos     = r_pos - ADDR_W'(1);
                    if (r_pos > ADDR_W'(1)) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_LAST;
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = S_REPORT;
                end
            end
            S_LAST: begin
                ram_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_moves  = t_moves'(r_shift);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift      <= n_shift;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_moves  <= n_out_moves;
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.status = r_out_status;
    assign o_result.moves  = r_out_moves;
    assign o_count         = r_count;
endmodule

/* rtl/sorted_array_insert_core.sv */
// ----------------------------------------------------------------------------
// sorted_array_insert_core: sorted insertion table
// Keeps an ascending table of signed values; reports shifts per insert.
// ----------------------------------------------------------------------------
// Usage:
//   i_value  (valid/ready) carries one signed 32-bit value per item.
//   o_result (valid/ready) returns one item per input: status (0 inserted,
//   1 table full, nothing changed) and moves, the count of entries that
//   shifted up to make room. Equal entries stay below the new value.
// Insert sequence:
//   The back end walks the table one entry per cycle through a single
//   RAM read port. An insert goes from idle through one compare state
//   per entry read (plus a last step when every entry moves) to the
//   report state; an insert into an empty table and a full-table item
//   go straight from idle to report. Items are taken one at a time by
//   the back end; a two-entry queue lets the front keep accepting while
//   the back end works.
// Reset:
//   Empties the table (count zero) and drops queued items and any pending
//   result. The table RAM needs no clearing pass.
// Stall:
//   If o_result.ready stays low, the result register holds, the back end
//   holds its next result, the queue fills and i_value.ready drops.
// ----------------------------------------------------------------------------
module sorted_array_insert_core #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sai_value_if.sink    i_value,
    sai_result_if.source o_result
);
    import sai_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             q_push;
    t_job             q_in_job;
    logic             q_full;
    logic             q_valid;
    t_job             q_out_job;
    logic             q_pop;
    logic [CNT_W-1:0] front_count;
    logic [CNT_W-1:0] back_count;

    // Classify each value against the committed insert count.
    sai_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in_job),
        .o_count  (front_count)
    );

    // Hold classified items between the two halves.
    sai_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // Carry out the insert in the table RAM and report.
    sai_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .o_result    (o_result),
        .o_count     (back_count)
    );

`ifndef SYNTH
    // The back end never holds more entries than the table has.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_count <= CNT_W'(CAPACITY))
        else $error("back end count exceeds capacity");

    // The front runs ahead of, never behind, the back end.
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_count <= front_count)
        else $error("front count fell behind back end count");

    // A full-table result reports no moves.
    a_full_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == ST_FULL) |-> (o_result.moves == '0))
        else $error("full result reports moves");
`endif
endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted insert core
// Feeds signed values through the input channel and compares each returned
// status and move count with a shadow copy of the sorted table. A short
// table of hand-picked probes comes first, then random values. The random
// values fill the table past capacity under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sai_pkg::*;

    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1585;
    localparam int MAX_GAP      = 20;
    // Slowest legal run: every insert walks the whole table, then add the
    // sender gaps and the receiver stalls. Allow about four times that.
    localparam int CYCLE_LIMIT  = 4_000_000;

    // What one insert returns.
    typedef struct {
        t_status status;
        t_moves  moves;
    } t_insert_outcome;

    // One hand-picked probe. Where known is set, the outcome is typed in;
    // otherwise the shadow table decides it.
    typedef struct {
        t_value  value;
        bit      known;
        t_status status;
        t_moves  moves;
    } t_probe_row;

    localparam int PROBE_COUNT = 15;

    // Rows build on each other, starting from an empty table.
    t_probe_row probes [0:PROBE_COUNT-1] = '{
        '{32'sh00000000, 1'b1, ST_INSERTED, 11'd0}, // first entry, nothing moves
        '{32'sh7FFFFFFF, 1'b1, ST_INSERTED, 11'd0}, // largest value goes last
        '{32'sh80000000, 1'b1, ST_INSERTED, 11'd2}, // smallest value shifts all
        '{32'sh00000000, 1'b1, ST_INSERTED, 11'd1}, // equal entry stays below
        '{32'sh7FFFFFFF, 1'b1, ST_INSERTED, 11'd0}, // equal to the top entry
        '{32'sh80000000, 1'b1, ST_INSERTED, 11'd4}, // equal to the bottom entry
        '{32'shFFFFFFFF, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh00000001, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh7FFFFFFE, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh80000001, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh55555555, 1'b0, ST_INSERTED, 11'd0},
        '{32'shAAAAAAAA, 1'b0, ST_INSERTED, 11'd0},
        '{32'shFFFFFFFF, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh00000001, 1'b0, ST_INSERTED, 11'd0},
        '{32'sh00000000, 1'b0, ST_INSERTED, 11'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sai_value_if  value_ch ();
    sai_result_if result_ch ();

    sorted_array_insert_core #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (value_ch),
        .o_result (result_ch)
    );

    // Shadow of the table contents, kept in ascending order.
    t_value          shadow_table [$];
    // Outcomes of accepted values, oldest first.
    t_insert_outcome awaited_results [$];

    int failures     = 0;
    int cycle_count  = 0;
    int send_idle_pct = 0;
    int stall_pct    = 0;
    bit quiet        = 1'b1;   // both sides run flat out while set

    always #2 i_clk = ~i_clk;

    // Place v after every entry less than or equal to it; count the entries
    // strictly above it, which are the ones the block has to move up.
    function automatic t_insert_outcome predict_insert(t_value v);
        t_insert_outcome outcome;
        int              pos;
        if (shadow_table.size() >= TABLE_DEPTH) begin
            outcome.status = ST_FULL;
            outcome.moves  = '0;
            return outcome;
        end
        pos = shadow_table.size();
        while (pos > 0 && shadow_table[pos-1] > v)
            pos--;
        outcome.status = ST_INSERTED;
        outcome.moves  = t_moves'(shadow_table.size() - pos);
        shadow_table.insert(pos, v);
        return outcome;
    endfunction

    // Append an outcome behind the ones still awaited.
    function automatic void record_outcome(t_insert_outcome o);
        awaited_results.insert(awaited_results.size(), o);
    endfunction

    // Mix wide random values with clusters that force equal entries and
    // values hugging both ends of the signed range.
    function automatic t_value pick_value();
        t_value v;
        case ($urandom_range(9))
            4, 5:    v = t_value'(int'($urandom_range(16)) - 8);
            6:       v = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            7:       v = 32'sh80000000 + t_value'($urandom_range(15));
            8:       v = 32'sh7FFFFFFF - t_value'($urandom_range(15));
            9: begin
                if (shadow_table.size() != 0)
                    v = shadow_table[$urandom_range(shadow_table.size() - 1)];
                else
                    v = t_value'($urandom);
            end
            default: v = t_value'($urandom);
        endcase
        return v;
    endfunction

    function automatic void note_failure(string what);
        if (failures < 10)
            $display("[%0t] MISMATCH %s", $realtime, what);
        failures++;
    endfunction

    // Draw a gap, then hold the value on the channel until it is taken. Only
    // one assignment to valid lands in any time step.
    task automatic send_value(t_value v, bit known, t_insert_outcome typed);
        int              gap;
        t_insert_outcome outcome;
        gap = 0;
        if (!quiet)
            while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
                gap++;
        if (gap > 0) begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do
            @(posedge i_clk);
        while (!value_ch.ready);
        outcome = predict_insert(v);
        record_outcome(known ? typed : outcome);
    endtask

    // Receiver: check every taken result against the oldest outcome, then
    // draw ready for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("unexpected result status=%0d moves=%0d",
                                           result_ch.status, result_ch.moves));
                end else begin
                    t_insert_outcome want;
                    want = awaited_results.pop_front();
                    if (result_ch.status !== want.status)
                        note_failure($sformatf("status: expected %0d, got %0d",
                                               want.status, result_ch.status));
                    if (result_ch.moves !== want.moves)
                        note_failure($sformatf("moves: expected %0d, got %0d",
                                               want.moves, result_ch.moves));
                end
            end
            result_ch.ready <= quiet || ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_insert_outcome typed;
        int              phase;
        i_rst_n         <= 1'b0;
        value_ch.valid  <= 1'b0;
        value_ch.value  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-picked probes, no idling.
        for (int row = 0; row < PROBE_COUNT; row++) begin
            typed.status = probes[row].status;
            typed.moves  = probes[row].moves;
            send_value(probes[row].value, probes[row].known, typed);
        end

        // Random values. The table fills part way through, after which every
        // item must come back full. Advance through the idle patterns in four
        // phases, with short quiet stretches inside the idling ones.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n * 4) / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 55; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            quiet = (phase == 0) || ((n / 40) % 5 == 0);
            send_value(pick_value(), 1'b0, typed);
        end
        value_ch.valid <= 1'b0;
        quiet = 1'b0;

        // Drain, then give a stray result time to surface.
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/sai_pkg.sv
rtl/sai_if.sv
rtl/sai_ram.sv
rtl/sai_queue.sv
rtl/sai_front.sv
rtl/sai_back.sv
rtl/sorted_array_insert_core.sv
verif/testbench.sv
